### hw/rtl/sad_pkg.sv
package sad_pkg;

    // Coordinate width of the point fields
    localparam int COORD_WIDTH = 16;
    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
    localparam int ANGLE_WIDTH = 9;

    // Octant search: boundaries 1..OCT_TOP, result 0..OCT_TOP
    localparam int OCT_TOP = 44;
    localparam int DEG_W   = 6;
    localparam int PROD_W  = COORD_WIDTH + 32;
    localparam int SUM_W   = COORD_WIDTH + 64;

    localparam logic [DEG_W-1:0] OCT_LAST = DEG_W'(OCT_TOP);
    localparam logic [6:0] DEG_DIAG    = 7'd45;
    localparam logic [6:0] DEG_QUAD_HI = 7'd89;
    localparam logic [ANGLE_WIDTH-1:0] DEG_90  = 9'd90;
    localparam logic [ANGLE_WIDTH-1:0] DEG_180 = 9'd180;
    localparam logic [ANGLE_WIDTH-1:0] DEG_270 = 9'd270;

    // Quadrant codes
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // Q2.62 constants
    localparam logic [63:0] PI_Q62  = 64'hC90FDAA22168C235;
    localparam logic [63:0] ONE_Q62 = 64'h4000000000000000;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] start_x;
        logic signed [COORD_WIDTH-1:0] start_y;
        logic signed [COORD_WIDTH-1:0] end_x;
        logic signed [COORD_WIDTH-1:0] end_y;
    } points_t;

    typedef struct packed {
        logic [ANGLE_WIDTH-1:0] angle_deg;
        logic                   zero_length;
    } result_t;

    // Context carried down the pipeline with each item
    typedef struct packed {
        logic [1:0]             quad;
        logic                   swap;
        logic                   zero;
        logic                   equal;
        logic [COORD_WIDTH-1:0] minor;
        logic [COORD_WIDTH-1:0] major;
        logic [DEG_W-1:0]       deg;
    } sad_ctx_t;

    typedef logic [63:0] trig_tab_t [0:OCT_TOP];

    // Taylor series of cos/sin at whole degrees, Q62, truncating steps.
    // Evaluated at elaboration only.
    function automatic trig_tab_t build_trig(logic want_sin);
        trig_tab_t    tab;
        logic [63:0]  step;
        logic [63:0]  x;
        logic [63:0]  term;
        logic [63:0]  c;
        logic [63:0]  s;
        logic [127:0] prod;
        step = PI_Q62 / 64'd180;
        tab[0] = want_sin ? 64'd0 : ONE_Q62;
        for (int k = 1; k <= OCT_TOP; k++)
        begin
            x    = step * 64'(k);
            term = ONE_Q62;
            c    = ONE_Q62;
            s    = 64'd0;
            for (int n = 1; n < 64; n++)
            begin
                if (term != 64'd0)
                begin
                    prod = {64'd0, term} * {64'd0, x};
                    term = prod[125:62] / 64'(n);
                    case (2'(n))
                        2'd1:    s = s + term;
                        2'd2:    c = c - term;
                        2'd3:    s = s - term;
                        default: c = c + term;
                    endcase
                end
            end
            tab[k] = want_sin ? s : c;
        end
        return tab;
    endfunction

    localparam trig_tab_t COS_Q62 = build_trig(1'b0);
    localparam trig_tab_t SIN_Q62 = build_trig(1'b1);

    function automatic logic [63:0] cos_at(logic [DEG_W-1:0] k);
        return (k <= OCT_LAST) ? COS_Q62[k] : 64'd0;
    endfunction

    function automatic logic [63:0] sin_at(logic [DEG_W-1:0] k);
        return (k <= OCT_LAST) ? SIN_Q62[k] : 64'd0;
    endfunction

endpackage

### hw/rtl/sad_front.sv
module sad_front
    import sad_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  points_t  up,
    input  logic     up_valid,
    output logic     up_stall,
    output sad_ctx_t dn,
    output logic     dn_valid,
    input  logic     dn_stall
);

    logic                         v1_reg;
    logic                         v2_reg;
    logic signed [DIFF_WIDTH-1:0] dx_reg;
    logic signed [DIFF_WIDTH-1:0] dy_reg;
    logic signed [DIFF_WIDTH-1:0] dx_next;
    logic signed [DIFF_WIDTH-1:0] dy_next;
    logic signed [DIFF_WIDTH-1:0] qx;
    logic signed [DIFF_WIDTH-1:0] qy;
    logic [COORD_WIDTH-1:0]       ux;
    logic [COORD_WIDTH-1:0]       uy;
    logic [1:0]                   quad;
    sad_ctx_t                     ctx_reg;
    sad_ctx_t                     ctx_next;
    logic                         rdy1;
    logic                         rdy2;

    assign rdy2     = !v2_reg || !dn_stall;
    assign rdy1     = !v1_reg || rdy2;
    assign up_stall = !rdy1;
    assign dn       = ctx_reg;
    assign dn_valid = v2_reg;

    // Vector from the two points, y flipped to point up
    assign dx_next = $signed({up.end_x[COORD_WIDTH-1], up.end_x})
                   - $signed({up.start_x[COORD_WIDTH-1], up.start_x});
    assign dy_next = $signed({up.start_y[COORD_WIDTH-1], up.start_y})
                   - $signed({up.end_y[COORD_WIDTH-1], up.end_y});

    // Rotate by a multiple of 90 degrees into the first quadrant
    always_comb
    begin
        if (dx_reg > 0 && dy_reg >= 0)
        begin
            quad = QUAD_0;
            qx   = dx_reg;
            qy   = dy_reg;
        end
        else if (dx_reg <= 0 && dy_reg > 0)
        begin
            quad = QUAD_1;
            qx   = dy_reg;
            qy   = -dx_reg;
        end
        else if (dx_reg < 0 && dy_reg <= 0)
        begin
            quad = QUAD_2;
            qx   = -dx_reg;
            qy   = -dy_reg;
        end
        else
        begin
            quad = QUAD_3;
            qx   = -dy_reg;
            qy   = dx_reg;
        end
    end

    assign ux = qx[COORD_WIDTH-1:0];
    assign uy = qy[COORD_WIDTH-1:0];

    // Mirror into the lower octant
    always_comb
    begin
        ctx_next.quad  = quad;
        ctx_next.swap  = uy > ux;
        ctx_next.zero  = (dx_reg == 0) && (dy_reg == 0);
        ctx_next.equal = uy == ux;
        ctx_next.minor = (uy > ux) ? ux : uy;
        ctx_next.major = (uy > ux) ? uy : ux;
        ctx_next.deg   = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= up_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && up_valid)
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
        if (rdy2 && v1_reg)
        begin
            ctx_reg <= ctx_next;
        end
    end

endmodule

### hw/rtl/sad_step.sv
module sad_step
    import sad_pkg::*;
#(
    parameter int BIT = 5
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  sad_ctx_t up,
    input  logic     up_valid,
    output logic     up_stall,
    output sad_ctx_t dn,
    output logic     dn_valid,
    input  logic     dn_stall
);

    localparam logic [DEG_W-1:0] CAND_BIT = DEG_W'(1) << BIT;

    logic              v1_reg;
    logic              v2_reg;
    logic              v3_reg;
    logic              v4_reg;
    sad_ctx_t          ctx1_reg;
    sad_ctx_t          ctx2_reg;
    sad_ctx_t          ctx3_reg;
    sad_ctx_t          ctx4_reg;
    sad_ctx_t          ctx4_next;
    logic [63:0]       cos1_reg;
    logic [63:0]       sin1_reg;
    logic [PROD_W-1:0] mc_hi2_reg;
    logic [PROD_W-1:0] mc_lo2_reg;
    logic [PROD_W-1:0] ms_hi2_reg;
    logic [PROD_W-1:0] ms_lo2_reg;
    logic [SUM_W-1:0]  lhs3_reg;
    logic [SUM_W-1:0]  rhs3_reg;
    logic [DEG_W-1:0]  cand_up;
    logic [DEG_W-1:0]  cand3;
    logic              rdy1;
    logic              rdy2;
    logic              rdy3;
    logic              rdy4;

    assign rdy4     = !v4_reg || !dn_stall;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign up_stall = !rdy1;
    assign dn       = ctx4_reg;
    assign dn_valid = v4_reg;

    // Trial degree: bits found so far plus this one
    assign cand_up = up.deg | CAND_BIT;
    assign cand3   = ctx3_reg.deg | CAND_BIT;

    // Keep the trial bit when it is at most OCT_LAST and minor*cos >= major*sin
    always_comb
    begin
        ctx4_next = ctx3_reg;
        if (cand3 <= OCT_LAST && lhs3_reg >= rhs3_reg)
        begin
            ctx4_next.deg = cand3;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= up_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        // Boundary constant lookup
        if (rdy1 && up_valid)
        begin
            ctx1_reg <= up;
            cos1_reg <= cos_at(cand_up);
            sin1_reg <= sin_at(cand_up);
        end
        // Partial products on 32-bit halves of the constants
        if (rdy2 && v1_reg)
        begin
            ctx2_reg   <= ctx1_reg;
            mc_hi2_reg <= PROD_W'(ctx1_reg.minor) * PROD_W'(cos1_reg[63:32]);
            mc_lo2_reg <= PROD_W'(ctx1_reg.minor) * PROD_W'(cos1_reg[31:0]);
            ms_hi2_reg <= PROD_W'(ctx1_reg.major) * PROD_W'(sin1_reg[63:32]);
            ms_lo2_reg <= PROD_W'(ctx1_reg.major) * PROD_W'(sin1_reg[31:0]);
        end
        // Full products
        if (rdy3 && v2_reg)
        begin
            ctx3_reg <= ctx2_reg;
            lhs3_reg <= {mc_hi2_reg, 32'd0} + SUM_W'(mc_lo2_reg);
            rhs3_reg <= {ms_hi2_reg, 32'd0} + SUM_W'(ms_lo2_reg);
        end
        if (rdy4 && v3_reg)
        begin
            ctx4_reg <= ctx4_next;
        end
    end

endmodule

### hw/rtl/sad_back.sv
module sad_back
    import sad_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  sad_ctx_t up,
    input  logic     up_valid,
    output logic     up_stall,
    output result_t  dn,
    output logic     dn_valid,
    input  logic     dn_stall
);

    logic                   v_reg;
    result_t                res_reg;
    result_t                res_next;
    logic [6:0]             oct;
    logic [6:0]             frac;
    logic [ANGLE_WIDTH-1:0] base;
    logic                   rdy;

    assign rdy      = !v_reg || !dn_stall;
    assign up_stall = !rdy;
    assign dn       = res_reg;
    assign dn_valid = v_reg;

    // Diagonal is exact; upper octant mirrors about 45 degrees
    assign oct  = up.equal ? DEG_DIAG : 7'(up.deg);
    assign frac = up.swap ? (DEG_QUAD_HI - oct) : oct;

    always_comb
    begin
        case (up.quad)
            QUAD_1:  base = DEG_90;
            QUAD_2:  base = DEG_180;
            QUAD_3:  base = DEG_270;
            default: base = '0;
        endcase
    end

    // Zero-length segment reports angle 0 with the flag
    always_comb
    begin
        res_next.zero_length = up.zero;
        res_next.angle_deg   = up.zero ? '0 : (base + ANGLE_WIDTH'(frac));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (rdy)
        begin
            v_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy && up_valid)
        begin
            res_reg <= res_next;
        end
    end

endmodule

### hw/rtl/segment_angle_degrees.sv
// Channel   Payload    Handshake                   Accepted when
// points    points_t   points_valid / points_stall valid && !stall
// result    result_t   result_valid / result_stall valid && !stall
//
// One item per cycle sustained while result_stall is low. Pipeline: 2 front
// stages, then a 6-step binary search over the degree boundaries at 4 stages per step
// (lookup, partial products, sums, compare), then the output register.
// rst_n clears every stage valid bit; payload registers are not reset.
// Each stage holds its item while the next one is full and stalled, so
// bubbles fill in and a stall drops or repeats nothing.
module segment_angle_degrees
    import sad_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  points_t points,
    input  logic    points_valid,
    output logic    points_stall,
    output result_t result,
    output logic    result_valid,
    input  logic    result_stall
);

    sad_ctx_t link_ctx   [0:DEG_W];
    logic     link_valid [0:DEG_W];
    logic     link_stall [0:DEG_W];

    // Vector, quadrant and octant fold
    sad_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up       (points),
        .up_valid (points_valid),
        .up_stall (points_stall),
        .dn       (link_ctx[0]),
        .dn_valid (link_valid[0]),
        .dn_stall (link_stall[0])
    );

    // One search step per degree bit, most significant first
    for (genvar i = 0; i < DEG_W; i++)
    begin : g_step
        sad_step #(
            .BIT (DEG_W - 1 - i)
        ) u_step
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .up       (link_ctx[i]),
            .up_valid (link_valid[i]),
            .up_stall (link_stall[i]),
            .dn       (link_ctx[i+1]),
            .dn_valid (link_valid[i+1]),
            .dn_stall (link_stall[i+1])
        );
    end

    // Unfold to the full circle
    sad_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up       (link_ctx[DEG_W]),
        .up_valid (link_valid[DEG_W]),
        .up_stall (link_stall[DEG_W]),
        .dn       (result),
        .dn_valid (result_valid),
        .dn_stall (result_stall)
    );

endmodule

### bench/segment_angle_checker.sv
`timescale 1ns / 1ps

// Watches both channels of segment_angle_degrees, predicts the angle of each
// accepted segment and compares it with the results in order.
module segment_angle_checker
    import sad_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  points_t     points,
    input  logic        points_valid,
    input  logic        points_stall,
    input  result_t     result,
    input  logic        result_valid,
    input  logic        result_stall,
    output int unsigned errors,
    output int unsigned outstanding
);

    // cos/sin of whole degrees, unsigned Q2.62
    logic [63:0] cos_q62 [0:OCT_TOP];
    logic [63:0] sin_q62 [0:OCT_TOP];

    result_t     pending_angles [$];
    result_t     want;
    int unsigned fail_count;

    // Taylor series at k degrees, truncating Q62 products and divisions
    initial
    begin
        logic [63:0]  deg_step;
        logic [63:0]  x;
        logic [63:0]  term;
        logic [63:0]  c;
        logic [63:0]  s;
        logic [127:0] wide;
        int           n;
        deg_step   = PI_Q62 / 64'd180;
        cos_q62[0] = ONE_Q62;
        sin_q62[0] = 64'd0;
        for (int k = 1; k <= OCT_TOP; k++)
        begin
            x    = deg_step * 64'(k);
            term = ONE_Q62;
            c    = ONE_Q62;
            s    = 64'd0;
            n    = 1;
            while (term != 64'd0 && n < 64)
            begin
                wide = 128'(term) * 128'(x);
                term = wide[125:62] / 64'(n);
                if (n % 4 == 1)
                    s = s + term;
                else if (n % 4 == 2)
                    c = c - term;
                else if (n % 4 == 3)
                    s = s - term;
                else
                    c = c + term;
                n++;
            end
            cos_q62[k] = c;
            sin_q62[k] = s;
        end
    end

    // floor of atan(minor / major) in degrees, 0 <= minor <= major, major > 0
    function automatic int unsigned octant_floor(logic [63:0] minor, logic [63:0] major);
        logic [127:0] lhs;
        logic [127:0] rhs;
        int unsigned  deg;
        deg = 0;
        if (minor == major)
            return int'(DEG_DIAG);
        for (int k = 1; k <= OCT_TOP; k++)
        begin
            lhs = 128'(minor) * 128'(cos_q62[k]);
            rhs = 128'(major) * 128'(sin_q62[k]);
            if (lhs >= rhs)
                deg = k;
        end
        return deg;
    endfunction

    function automatic result_t predict_angle(points_t p);
        longint                 dx;
        longint                 dy;
        longint                 qx;
        longint                 qy;
        logic [1:0]             quad;
        logic [ANGLE_WIDTH-1:0] base;
        int unsigned            f;
        result_t                r;
        dx = longint'(p.end_x) - longint'(p.start_x);
        dy = longint'(p.start_y) - longint'(p.end_y);
        r.angle_deg   = '0;
        r.zero_length = 1'b0;
        if (dx == 0 && dy == 0)
        begin
            r.zero_length = 1'b1;
            return r;
        end
        // rotate into the first quadrant: qx > 0, qy >= 0
        if (dx > 0 && dy >= 0)
        begin
            quad = QUAD_0; qx = dx;  qy = dy;
        end
        else if (dx <= 0 && dy > 0)
        begin
            quad = QUAD_1; qx = dy;  qy = -dx;
        end
        else if (dx < 0 && dy <= 0)
        begin
            quad = QUAD_2; qx = -dx; qy = -dy;
        end
        else
        begin
            quad = QUAD_3; qx = -dy; qy = dx;
        end
        case (quad)
            QUAD_0:  base = '0;
            QUAD_1:  base = DEG_90;
            QUAD_2:  base = DEG_180;
            default: base = DEG_270;
        endcase
        // mirror the upper octant onto the lower one
        if (qy <= qx)
            f = octant_floor(qy, qx);
        else
            f = int'(DEG_QUAD_HI) - octant_floor(qx, qy);
        r.angle_deg = base + ANGLE_WIDTH'(f);
        return r;
    endfunction

    // predict on every accepted segment, compare on every accepted result
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            fail_count = 0;
            pending_angles.delete();
        end
        else
        begin
            if (points_valid && !points_stall)
                pending_angles.push_back(predict_angle(points));
            if (result_valid && !result_stall)
            begin
                if (pending_angles.size() == 0)
                begin
                    $error("result: unexpected item, angle_deg %0d zero_length %0b",
                           result.angle_deg, result.zero_length);
                    fail_count++;
                end
                else
                begin
                    want = pending_angles.pop_front();
                    if (result.angle_deg !== want.angle_deg)
                    begin
                        $error("angle_deg: expected %0d, actual %0d",
                               want.angle_deg, result.angle_deg);
                        fail_count++;
                    end
                    if (result.zero_length !== want.zero_length)
                    begin
                        $error("zero_length: expected %0b, actual %0b",
                               want.zero_length, result.zero_length);
                        fail_count++;
                    end
                end
            end
        end
        errors      <= fail_count;
        outstanding <= pending_angles.size();
    end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb
    import sad_pkg::*;
();

    localparam int  WATCHDOG_LIMIT   = 4000;
    localparam int  DRAIN_CYCLES     = 40;
    localparam int  RANDOM_PER_PHASE = 141;
    localparam real DEG_TO_RAD       = 3.14159265358979 / 180.0;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    points_t     points       = '0;
    logic        points_valid = 1'b0;
    logic        points_stall;
    result_t     result;
    logic        result_valid;
    logic        result_stall = 1'b0;

    int unsigned errors;
    int unsigned outstanding;
    int unsigned send_idle    = 0;
    int unsigned stall_pct    = 0;
    int unsigned quiet_cycles = 0;

    segment_angle_degrees u_top (
        .clk,
        .rst_n,
        .points,
        .points_valid,
        .points_stall,
        .result,
        .result_valid,
        .result_stall
    );

    segment_angle_checker u_checker (
        .clk,
        .rst_n,
        .points,
        .points_valid,
        .points_stall,
        .result,
        .result_valid,
        .result_stall,
        .errors,
        .outstanding
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // receiver back-pressure
    always @(posedge clk)
        result_stall <= ($urandom_range(99) < stall_pct);

    // end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((points_valid && !points_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // present one segment after a random gap, return at the accepting edge
    task automatic send_points(points_t p);
        while ($urandom_range(99) < send_idle)
        begin
            points_valid <= 1'b0;
            @(posedge clk);
        end
        points       <= p;
        points_valid <= 1'b1;
        do
            @(posedge clk);
        while (points_stall !== 1'b0);
    endtask

    // segment with the given dx, dy placed at a random legal start point
    task automatic send_vector(longint dx, longint dy);
        longint  lo;
        longint  hi;
        longint  sx;
        longint  sy;
        points_t p;
        lo = (dx < 0) ? -32768 - dx : -32768;
        hi = (dx > 0) ? 32767 - dx : 32767;
        sx = lo + longint'($urandom_range(32'(hi - lo)));
        lo = (dy > 0) ? dy - 32768 : -32768;
        hi = (dy < 0) ? 32767 + dy : 32767;
        sy = lo + longint'($urandom_range(32'(hi - lo)));
        p.start_x = 16'(sx);
        p.start_y = 16'(sy);
        p.end_x   = 16'(sx + dx);
        p.end_y   = 16'(sy - dy);
        send_points(p);
    endtask

    function automatic longint pick_extreme();
        case ($urandom_range(6))
            0:       return 65535;
            1:       return -65535;
            2:       return 65534;
            3:       return -65534;
            4:       return 32768;
            5:       return -32768;
            default: return longint'($urandom_range(131070)) - 65535;
        endcase
    endfunction

    task automatic random_segment();
        int unsigned mode;
        int unsigned k;
        longint      dx;
        longint      dy;
        longint      m;
        real         ang;
        real         radius;
        mode = $urandom_range(99);
        if (mode < 25)
            send_points({$urandom, $urandom});
        else if (mode < 40)
        begin
            // short segments, zero length among them
            dx = longint'($urandom_range(8)) - 4;
            dy = longint'($urandom_range(8)) - 4;
            send_vector(dx, dy);
        end
        else if (mode < 70)
        begin
            // near a whole-degree boundary
            k      = $urandom_range(359);
            ang    = (k + $urandom_range(999) / 1000.0) * DEG_TO_RAD;
            radius = 1.0 + $urandom_range($urandom_range(1) ? 46000 : 200);
            dx     = $rtoi(radius * $cos(ang)) + longint'($urandom_range(4)) - 2;
            dy     = $rtoi(radius * $sin(ang)) + longint'($urandom_range(4)) - 2;
            send_vector(dx, dy);
        end
        else if (mode < 85)
        begin
            // on or next to an axis or a diagonal
            m = 1 + longint'($urandom_range($urandom_range(1) ? 65533 : 20));
            case ($urandom_range(7))
                0:       send_vector(m, 0);
                1:       send_vector(0, m);
                2:       send_vector(-m, 0);
                3:       send_vector(0, -m);
                4:       send_vector(m, m + longint'($urandom_range(2)) - 1);
                5:       send_vector(-m, m + longint'($urandom_range(2)) - 1);
                6:       send_vector(-m, -m + longint'($urandom_range(2)) - 1);
                default: send_vector(m, -m + longint'($urandom_range(2)) - 1);
            endcase
        end
        else
            send_vector(pick_extreme(), pick_extreme());
    endtask

    initial
    begin
        int unsigned phase;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero length, axes, diagonals and full-range components
        send_points('0);
        send_points({4{16'h8000}});
        send_points({4{16'h7fff}});
        send_vector(1, 0);
        send_vector(0, 1);
        send_vector(-1, 0);
        send_vector(0, -1);
        send_vector(65535, 0);
        send_vector(0, 65535);
        send_vector(-65535, 0);
        send_vector(0, -65535);
        send_vector(7, 7);
        send_vector(-7, 7);
        send_vector(-7, -7);
        send_vector(7, -7);
        send_points({16'h8000, 16'h7fff, 16'h7fff, 16'h8000});
        send_points({16'h7fff, 16'h8000, 16'h8000, 16'h7fff});
        send_vector(65535, 1);
        send_vector(65535, 65534);
        send_vector(1, 65535);
        send_vector(-65535, 1);
        send_vector(65534, -65535);
        send_vector(1, 2);

        // random segments under each traffic pattern, twice over
        for (phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0:       begin send_idle = 0;  stall_pct = 0;  end
                1:       begin send_idle = 66; stall_pct = 0;  end
                2:       begin send_idle = 0;  stall_pct = 66; end
                default: begin send_idle = 21; stall_pct = 21; end
            endcase
            repeat (RANDOM_PER_PHASE) random_segment();
        end
        points_valid <= 1'b0;
        stall_pct = 0;

        // drain
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
